@@ design/swv_pkg.sv @@
package swv_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SQUARE_W = 32;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int VAR_W    = 31;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [VAR_W-1:0]           variance_t;

  // what the window hands to the statistics pipeline for each item
  typedef struct packed {
    sample_t sample;
    sample_t oldest;
    logic    full;
  } win_item_t;

endpackage

@@ design/swv_cell.sv @@
module swv_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  swv_pkg::sample_t d,
  output swv_pkg::sample_t q
);

  swv_pkg::sample_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

@@ design/swv_stats.sv @@
module swv_stats #(
  parameter int WINDOW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  swv_pkg::win_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output swv_pkg::variance_t  out_variance,
  output logic                out_window_full
);

  localparam int L      = $clog2(WINDOW);
  localparam int SUM_W  = swv_pkg::SAMPLE_W + 1 + L;
  localparam int MAG_W  = SUM_W - 1;
  localparam int SQS_W  = swv_pkg::SQUARE_W + L;
  localparam int PROD_W = 2 * MAG_W;

  // stage valids and their advance conditions
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || !out_stall;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_stall = !rdy1;

  // stage 1: item as taken from the window
  swv_pkg::win_item_t s1_r;

  // stage 2: squares and sample difference
  logic [swv_pkg::SQUARE_W-1:0]     sqs_r, sqo_r;
  logic signed [swv_pkg::DIFF_W-1:0] dif_r;
  logic                              full2_r;
  logic signed [swv_pkg::SQUARE_W-1:0] sqs_c, sqo_c;
  logic signed [swv_pkg::DIFF_W-1:0]   dif_nxt;

  assign sqs_c   = s1_r.sample * s1_r.sample;
  assign sqo_c   = s1_r.oldest * s1_r.oldest;
  assign dif_nxt = {s1_r.sample[swv_pkg::SAMPLE_W-1], s1_r.sample}
                 - {s1_r.oldest[swv_pkg::SAMPLE_W-1], s1_r.oldest};

  // stage 3: running sums, the only loop in the datapath
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQS_W-1:0]        sumsq_r, sumsq_nxt;
  logic                    full3_r;

  assign sum_nxt   = sum_r + {{(SUM_W-swv_pkg::DIFF_W){dif_r[swv_pkg::DIFF_W-1]}}, dif_r};
  assign sumsq_nxt = sumsq_r - {{L{1'b0}}, sqo_r} + {{L{1'b0}}, sqs_r};

  // stage 4: N*sum_sq (a shift by L, exact for a power-of-two WINDOW) and sum^2
  logic [PROD_W-1:0] sum2_r, prod_r;
  logic              full4_r;
  logic [MAG_W-1:0]  mag;
  logic [SUM_W-1:0]  neg_sum;

  assign neg_sum = -sum_r;
  assign mag     = sum_r[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_r[MAG_W-1:0];

  // stage 5: subtract and scale down by N*N (a shift by 2*L)
  swv_pkg::variance_t var_r, var_nxt;
  logic               full5_r;
  logic [PROD_W-1:0]  spread;

  assign spread  = prod_r - sum2_r;
  assign var_nxt = (full4_r && (prod_r > sum2_r)) ? spread[2*L +: swv_pkg::VAR_W] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      sum_r   <= '0;
      sumsq_r <= '0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy3 && v2_r) begin
        sum_r   <= sum_nxt;
        sumsq_r <= sumsq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_r <= in_item;
    end
    if (rdy2 && v1_r) begin
      sqs_r   <= unsigned'(sqs_c);
      sqo_r   <= unsigned'(sqo_c);
      dif_r   <= dif_nxt;
      full2_r <= s1_r.full;
    end
    if (rdy3 && v2_r) begin
      full3_r <= full2_r;
    end
    if (rdy4 && v3_r) begin
      sum2_r  <= mag * mag;
      prod_r  <= {sumsq_r, {L{1'b0}}};
      full4_r <= full3_r;
    end
    if (rdy5 && v4_r) begin
      var_r   <= var_nxt;
      full5_r <= full4_r;
    end
  end

  assign out_valid       = v5_r;
  assign out_variance    = var_r;
  assign out_window_full = full5_r;

endmodule

@@ design/sliding_window_variance_top.sv @@
// Sliding-window population variance of a signed 16-bit sample stream.
//
// Input channel: in_valid / in_stall with in_sample. An item is taken at a
// clock edge where in_valid is high and in_stall is low.
// Result channel: out_valid / out_stall with out_variance and
// out_window_full, one result per input item, in input order.
//
// The window is a row of WINDOW cells that shifts by one on each accepted
// item; the cell at the far end supplies the sample leaving the window.
// Each item passes through the registered stages item, squares, sums,
// products and scale; the block takes one item per cycle while in_stall
// is low, a rate set by the running-sum loop in the sums stage. Until
// WINDOW items have been taken, out_variance is 0 and out_window_full low.
//
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the cells,
// both sums and the fill count. While out_stall is high the result holds;
// the five pipeline stages keep filling, and in_stall rises once they are
// all occupied.
module sliding_window_variance_top #(
  parameter int WINDOW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [30:0]         out_variance,
  output logic                out_window_full
);

  localparam int FILL_W = $clog2(WINDOW + 1);

  logic             accept;
  swv_pkg::sample_t tap [WINDOW+1];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  swv_pkg::win_item_t item;

  assign accept = in_valid && !in_stall;
  assign tap[0] = in_sample;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    swv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .d        (tap[i]),
      .q        (tap[i+1])
    );
  end

  assign fill_nxt = (fill_r == FILL_W'(WINDOW)) ? fill_r : fill_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  // until the window is full the last cell still holds its reset zero
  assign item.sample = in_sample;
  assign item.oldest = tap[WINDOW];
  assign item.full   = (fill_r >= FILL_W'(WINDOW - 1));

  swv_stats #(
    .WINDOW (WINDOW)
  ) u_stats (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_variance    (out_variance),
    .out_window_full (out_window_full)
  );

endmodule

@@ dv/swv_result_checker.sv @@
`timescale 1ns / 100ps

module swv_result_checker #(
  parameter int WINDOW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  swv_pkg::sample_t      in_sample,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  swv_pkg::variance_t    out_variance,
  input  logic                  out_window_full,
  output int                    mismatches,
  output int                    samples_taken,
  output int                    results_seen
);

  localparam int SUM_W    = swv_pkg::SAMPLE_W + $clog2(WINDOW) + 1;
  localparam int SQ_SUM_W = swv_pkg::SQUARE_W + $clog2(WINDOW);
  localparam int REPORT_MAX = 10;

  typedef struct {
    swv_pkg::variance_t variance;
    logic               window_full;
  } var_result_t;

  var_result_t                 pending_variances[$];
  swv_pkg::sample_t            window_cells[WINDOW];
  logic signed [SUM_W-1:0]     win_sum;
  logic [SQ_SUM_W-1:0]         win_sum_sq;
  int                          fill_count;
  int                          write_slot;

  function automatic logic [swv_pkg::SQUARE_W-1:0] square_of(swv_pkg::sample_t v);
    longint w;
    w = v;
    return swv_pkg::SQUARE_W'(w * w);
  endfunction

  // advance the window by one sample and work out the variance it gives
  function automatic var_result_t window_variance_step(swv_pkg::sample_t s);
    swv_pkg::sample_t     oldest;
    longint               sm;
    longint unsigned      mag;
    longint unsigned      prod;
    longint unsigned      sum2;
    var_result_t          r;
    oldest = (fill_count >= WINDOW) ? window_cells[write_slot] : '0;
    win_sum = win_sum + s - oldest;
    win_sum_sq = win_sum_sq - square_of(oldest) + square_of(s);
    window_cells[write_slot] = s;
    write_slot = (write_slot + 1) % WINDOW;
    if (fill_count < WINDOW) fill_count++;
    r.variance = '0;
    r.window_full = 1'b0;
    if (fill_count >= WINDOW) begin
      sm = win_sum;
      mag = (sm < 0) ? -sm : sm;
      sum2 = mag * mag;
      prod = longint'(WINDOW) * win_sum_sq;
      r.window_full = 1'b1;
      if (prod > sum2)
        r.variance = swv_pkg::variance_t'((prod - sum2) /
                                          (longint'(WINDOW) * longint'(WINDOW)));
    end
    return r;
  endfunction

  task automatic note_failure(string msg);
    if (mismatches < REPORT_MAX) $display("[%0t] %s", $realtime, msg);
    mismatches++;
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin : watch_channels
    var_result_t want;
    if (!rst_n) begin
      pending_variances.delete();
      foreach (window_cells[i]) window_cells[i] = '0;
      win_sum = '0;
      win_sum_sq = '0;
      fill_count = 0;
      write_slot = 0;
      samples_taken <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (pending_variances.size() == 0) begin
          note_failure($sformatf("result %0d with no item outstanding: variance %0d full %0b",
                                 results_seen, out_variance, out_window_full));
        end else begin
          want = pending_variances.pop_front();
          if (out_variance !== want.variance || out_window_full !== want.window_full)
            note_failure($sformatf({"result %0d: expected variance %0d full %0b, ",
                                    "got variance %0d full %0b"},
                                   results_seen, want.variance, want.window_full,
                                   out_variance, out_window_full));
        end
      end
      if (in_valid && !in_stall) begin
        samples_taken <= samples_taken + 1;
        pending_variances.push_back(window_variance_step(in_sample));
      end
    end
  end

endmodule

@@ dv/sliding_window_variance_top_test.sv @@
`timescale 1ns / 100ps

module sliding_window_variance_top_test;

  localparam int WINDOW       = 16;
  localparam int PHASE_ITEMS  = 300;
  localparam int HOLD_CYCLES  = 40;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam swv_pkg::sample_t SAMPLE_MIN = 16'sh8000;
  localparam swv_pkg::sample_t SAMPLE_MAX = 16'sh7fff;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  swv_pkg::sample_t   in_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  swv_pkg::variance_t out_variance;
  logic               out_window_full;

  int                 snd_idle_pct = 0;
  int                 rcv_stall_pct = 0;
  logic               hold_request = 1'b0;
  int                 quiet_cycles = 0;
  swv_pkg::sample_t   last_sample = '0;
  int                 mismatches;
  int                 samples_taken;
  int                 results_seen;

  sliding_window_variance_top #(.WINDOW(WINDOW)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_variance    (out_variance),
    .out_window_full (out_window_full)
  );

  swv_result_checker #(.WINDOW(WINDOW)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_variance    (out_variance),
    .out_window_full (out_window_full),
    .mismatches      (mismatches),
    .samples_taken   (samples_taken),
    .results_seen    (results_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: random stalls, or one long hold-off when asked for
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no handshake for %0d cycles", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // valid stays high from one item to the next unless an idle cycle is drawn
  task automatic send_sample(swv_pkg::sample_t s);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_seen != samples_taken) @(posedge clk);
  endtask

  // extremes, small values and repeats (runs of equal samples drive the variance to zero)
  function automatic swv_pkg::sample_t random_sample();
    swv_pkg::sample_t r;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       r = SAMPLE_MIN;
          1:       r = SAMPLE_MAX;
          2:       r = '0;
          default: r = -16'sd1;
        endcase
      end
      1, 2:    r = swv_pkg::sample_t'(int'($urandom_range(16)) - 8);
      3, 4:    r = last_sample;
      default: r = swv_pkg::sample_t'($urandom);
    endcase
    last_sample = r;
    return r;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // alternating extremes fill the window at the widest spread, then the
    // oldest ones are pushed out by a run of the minimum
    for (int i = 0; i < WINDOW; i++) send_sample((i % 2) ? SAMPLE_MAX : SAMPLE_MIN);
    repeat (6) send_sample(SAMPLE_MIN);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample('0);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 29;
          rcv_stall_pct = 62;
        end
        1: begin
          snd_idle_pct = 62;
          rcv_stall_pct = 29;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 0;
          hold_request = 1'b1;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(random_sample());
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/swv_pkg.sv
design/swv_cell.sv
design/swv_stats.sv
design/sliding_window_variance_top.sv
dv/swv_result_checker.sv
dv/sliding_window_variance_top_test.sv
